### sv/mm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types and constants of the masked median block.
// ----------------------------------------------------------------------------
package mm_pkg;

	localparam int SAMPLE_W = 32;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SHIFT,
		ST_DONE
	} state_t;

	// control broadcast along a sorting chain
	typedef struct packed {
		logic    insert;
		logic    shift;
		sample_t sample;
	} cell_ctl_t;

endpackage

### sv/mm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_cell
// One slot of an insertion-sorting chain: holds one sample, takes its left
// neighbor's value on insert when both exceed the new sample, the new sample
// when only it does, and its right neighbor's value on a shift toward the head.
// ----------------------------------------------------------------------------
module mm_cell (
	input  logic              clk,
	input  mm_pkg::cell_ctl_t ctl,
	input  logic              occupied,
	input  mm_pkg::sample_t   left_value,
	input  logic              left_gt,
	input  mm_pkg::sample_t   right_value,
	output mm_pkg::sample_t   value,
	output logic              gt
);
	import mm_pkg::*;

	sample_t value_q;

	// an empty slot counts as larger than any sample
	assign gt    = !occupied || (value_q > ctl.sample);
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (ctl.insert && gt) begin
			value_q <= left_gt ? left_value : ctl.sample;
		end else if (ctl.shift) begin
			value_q <= right_value;
		end
	end

endmodule

### sv/mm_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_chain
// Row of sorting cells keeping its samples in ascending order from the head.
// ----------------------------------------------------------------------------
module mm_chain #(
	parameter int DEPTH = 1024,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  mm_pkg::cell_ctl_t ctl,
	input  logic [CW-1:0]     count,
	output mm_pkg::sample_t   head0,
	output mm_pkg::sample_t   head1
);
	import mm_pkg::*;

	sample_t values [DEPTH];
	logic    gts    [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		sample_t left_v;
		logic    left_g;
		sample_t right_v;

		if (i == 0) begin : g_head
			assign left_v = ctl.sample;
			assign left_g = 1'b0;
		end else begin : g_body
			assign left_v = values[i-1];
			assign left_g = gts[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_v = values[i];
		end else begin : g_mid
			assign right_v = values[i+1];
		end

		mm_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (CW'(i) < count),
			.left_value  (left_v),
			.left_gt     (left_g),
			.right_value (right_v),
			.value       (values[i]),
			.gt          (gts[i])
		);
	end

	assign head0 = values[0];
	assign head1 = values[1];

endmodule

### sv/masked_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_median
// Median of a streamed sample set under a keep mask, by insertion sorting.
// ----------------------------------------------------------------------------
// Input channel: sample, keep, last with in_valid / in_stall. A beat is taken
// when in_valid is high and in_stall is low. Samples of a set are taken one
// per cycle; each is sorted into a chain of all samples and, when keep is
// set, into a chain of kept samples. Samples beyond MAX_SAMPLES are dropped
// and reported through overflowed.
// After the beat marked last, in_stall rises while the selected chain shifts
// toward its head until the lower middle element sits in the first cell: the
// walk runs through the setup, shift and done states before the result is
// registered, and its shifts number the lower middle index of the samples used.
// Output channel: median_value, fallback_used, overflowed with out_valid /
// out_stall. A valid result holds in its register while out_stall is high;
// the block keeps in_stall high until a finished result can enter it.
// Reset clears counts, flags, the state and out_valid; chain contents are
// only read below the counts and need no clearing.
// ----------------------------------------------------------------------------
module masked_median #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [31:0]     sample,
	input  logic                   keep,
	input  logic                   last,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [31:0]     median_value,
	output logic                   fallback_used,
	output logic                   overflowed
);
	import mm_pkg::*;

	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);

	state_t        state_q, state_d;
	logic [CW-1:0] total_count_q, kept_count_q;
	logic [CW-1:0] shift_q;
	logic          overflow_q;
	logic          use_kept_q;
	logic          out_valid_q;
	sample_t       median_q;
	logic          fallback_q, overflowed_q;

	logic          in_accept, room, do_shift, load_out;
	logic [CW-1:0] sel_count;
	cell_ctl_t     all_ctl, kept_ctl;
	sample_t       all_h0, all_h1, kept_h0, kept_h1, h0, h1;
	logic signed [SAMPLE_W:0] pair_sum;
	sample_t       median_d;

	assign in_accept = in_valid && !in_stall;
	assign room      = total_count_q < MAX_CNT;

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		do_shift = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && last) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (shift_q == '0) begin
					state_d = ST_DONE;
				end else begin
					do_shift = 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign sel_count = (kept_count_q != '0) ? kept_count_q : total_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_count_q <= '0;
			kept_count_q  <= '0;
			overflow_q    <= 1'b0;
			shift_q       <= '0;
			use_kept_q    <= 1'b0;
		end else begin
			if (in_accept) begin
				if (room) begin
					total_count_q <= total_count_q + 1'b1;
					if (keep) begin
						kept_count_q <= kept_count_q + 1'b1;
					end
				end else begin
					overflow_q <= 1'b1;
				end
			end
			if (state_q == ST_SETUP) begin
				// lower middle index serves odd and even counts alike
				shift_q    <= (sel_count - 1'b1) >> 1;
				use_kept_q <= kept_count_q != '0;
			end else if (do_shift) begin
				shift_q <= shift_q - 1'b1;
			end
			if (load_out) begin
				total_count_q <= '0;
				kept_count_q  <= '0;
				overflow_q    <= 1'b0;
			end
		end
	end

	always_comb begin
		all_ctl.insert  = in_accept && room;
		all_ctl.shift   = do_shift;
		all_ctl.sample  = sample;
		kept_ctl.insert = in_accept && room && keep;
		kept_ctl.shift  = do_shift;
		kept_ctl.sample = sample;
	end

	mm_chain #(
		.DEPTH (MAX_SAMPLES),
		.CW    (CW)
	) u_all (
		.clk   (clk),
		.ctl   (all_ctl),
		.count (total_count_q),
		.head0 (all_h0),
		.head1 (all_h1)
	);

	mm_chain #(
		.DEPTH (MAX_SAMPLES),
		.CW    (CW)
	) u_kept (
		.clk   (clk),
		.ctl   (kept_ctl),
		.count (kept_count_q),
		.head0 (kept_h0),
		.head1 (kept_h1)
	);

	assign h0       = use_kept_q ? kept_h0 : all_h0;
	assign h1       = use_kept_q ? kept_h1 : all_h1;
	assign pair_sum = {h0[SAMPLE_W-1], h0} + {h1[SAMPLE_W-1], h1};
	// odd count takes the middle cell, even count the floor of the pair mean
	assign median_d = sel_count[0] ? h0 : pair_sum[SAMPLE_W:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			median_q     <= median_d;
			fallback_q   <= !use_kept_q;
			overflowed_q <= overflow_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign median_value  = median_q;
	assign fallback_used = fallback_q;
	assign overflowed    = overflowed_q;

`ifndef SYNTHESIS
	a_last_starts_readout: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && last) |=> (state_q == ST_SETUP))
		else $error("last beat did not start readout");

	a_total_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		total_count_q <= MAX_CNT)
		else $error("sample count exceeds capacity");

	a_kept_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		kept_count_q <= total_count_q)
		else $error("kept count exceeds total count");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> $stable(median_q))
		else $error("stalled result overwritten");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sample sets into masked_median and checks each median result.
// ----------------------------------------------------------------------------
// A table of hand-picked sets runs first; most of its results are typed in.
// Random sets follow, then one set that fills the block to capacity and
// overflows on its final beat. A sorted-list model tracks every accepted beat
// and predicts each median, fallback and overflow. Both channels idle at
// random; the receiver also holds off for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module testbench;

	import mm_pkg::sample_t;

	localparam int CAPACITY    = 1024;
	localparam int RAND_ITEMS  = 150;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = CAPACITY / 2 + 8;
	localparam int CYCLE_LIMIT = 600000;
	localparam int NUM_ROWS    = 25;

	localparam sample_t S_MAX = 32'sh7FFFFFFF;
	localparam sample_t S_MIN = 32'sh80000000;

	typedef struct {
		sample_t med;
		logic    fb;
		logic    ov;
	} median_exp_t;

	typedef struct packed {
		sample_t s;
		logic    k;
		logic    l;
		logic    typed;
		sample_t med;
		logic    fb;
	} stim_row_t;

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_stall;
	sample_t        sample;
	logic           keep;
	logic           last;
	logic           out_valid;
	logic           out_stall;
	sample_t        median_value;
	logic           fallback_used;
	logic           overflowed;

	median_exp_t    median_q[$];
	sample_t        all_q[$];
	sample_t        kept_q[$];
	logic           dropped;
	int             mismatches;
	int             cycle_count;
	logic           steady;
	logic           hold_req;

	stim_row_t directed_rows [NUM_ROWS] = '{
		'{S_MAX,         1'b1, 1'b1, 1'b1, S_MAX,         1'b0},
		'{S_MIN,         1'b0, 1'b1, 1'b1, S_MIN,         1'b1},
		'{S_MAX,         1'b1, 1'b0, 1'b0, 32'sd0,        1'b0},
		'{S_MAX,         1'b1, 1'b1, 1'b1, S_MAX,         1'b0},
		'{S_MIN,         1'b1, 1'b0, 1'b0, 32'sd0,        1'b0},
		'{S_MIN,         1'b1, 1'b1, 1'b1, S_MIN,         1'b0},
		'{S_MIN,         1'b1, 1'b0, 1'b0, 32'sd0,        1'b0},
		'{S_MAX,         1'b1, 1'b1, 1'b1, -32'sd1,       1'b0},
		'{32'sd0,        1'b1, 1'b0, 1'b0, 32'sd0,        1'b0},
		'{-32'sd1,       1'b1, 1'b1, 1'b1, -32'sd1,       1'b0},
		'{32'sd2,        1'b1, 1'b0, 1'b0, 32'sd0,        1'b0},
		'{32'sd1,        1'b1, 1'b1, 1'b1, 32'sd1,        1'b0},
		'{32'sd3,        1'b0, 1'b0, 1'b0, 32'sd0,        1'b0},
		'{32'sd5,        1'b0, 1'b1, 1'b1, 32'sd4,        1'b1},
		'{32'sd10,       1'b0, 1'b0, 1'b0, 32'sd0,        1'b0},
		'{-32'sd7,       1'b1, 1'b0, 1'b0, 32'sd0,        1'b0},
		'{32'sd100,      1'b0, 1'b0, 1'b0, 32'sd0,        1'b0},
		'{32'sd3,        1'b1, 1'b0, 1'b0, 32'sd0,        1'b0},
		'{32'sd50,       1'b1, 1'b1, 1'b1, 32'sd3,        1'b0},
		'{32'sd9,        1'b0, 1'b0, 1'b0, 32'sd0,        1'b0},
		'{-32'sd9,       1'b0, 1'b0, 1'b0, 32'sd0,        1'b0},
		'{32'sd0,        1'b0, 1'b1, 1'b0, 32'sd0,        1'b0},
		'{32'shFFFF8000, 1'b1, 1'b0, 1'b0, 32'sd0,        1'b0},
		'{32'sh00018000, 1'b0, 1'b0, 1'b0, 32'sd0,        1'b0},
		'{32'sh00004000, 1'b1, 1'b1, 1'b0, 32'sd0,        1'b0}
	};

	masked_median #(
		.MAX_SAMPLES(CAPACITY)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.keep         (keep),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.median_value (median_value),
		.fallback_used(fallback_used),
		.overflowed   (overflowed)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic sorted_insert(ref sample_t q[$], input sample_t v);
		int pos;
		pos = q.size();
		while (pos > 0 && q[pos - 1] > v)
			pos--;
		q.insert(pos, v);
	endtask

	function automatic sample_t middle_of(sample_t q[$]);
		int                 n;
		logic signed [32:0] sum;
		n = q.size();
		if (n % 2 == 1)
			return q[(n - 1) / 2];
		sum = {q[n / 2 - 1][31], q[n / 2 - 1]} + {q[n / 2][31], q[n / 2]};
		return sum[32:1];
	endfunction

	task automatic absorb_beat(input sample_t s, input logic k, input logic l,
			output logic produced, output median_exp_t e);
		if (all_q.size() < CAPACITY) begin
			sorted_insert(all_q, s);
			if (k)
				sorted_insert(kept_q, s);
		end else begin
			dropped = 1'b1;
		end
		produced = l;
		if (l) begin
			if (kept_q.size() > 0) begin
				e.med = middle_of(kept_q);
				e.fb  = 1'b0;
			end else begin
				e.med = middle_of(all_q);
				e.fb  = 1'b1;
			end
			e.ov = dropped;
			all_q.delete();
			kept_q.delete();
			dropped = 1'b0;
		end
	endtask

	// entered and left just after a rising edge
	task automatic offer_beat(input sample_t s, input logic k, input logic l,
			input logic typed, input sample_t med, input logic fb);
		logic        produced;
		median_exp_t e;
		while (!steady && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		keep     <= k;
		last     <= l;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
		absorb_beat(s, k, l, produced, e);
		if (produced) begin
			if (typed) begin
				e.med = med;
				e.fb  = fb;
				e.ov  = 1'b0;
			end
			median_q.push_back(e);
		end
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(9))
			0: return S_MAX;
			1: return S_MIN;
			2: return $urandom_range(1) ? 32'sd0 : -32'sd1;
			3, 4: return $signed($urandom_range(40)) - 32'sd20;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_set(input int len);
		int   mode;
		logic k;
		mode = $urandom_range(3);
		for (int i = 0; i < len; i++) begin
			case (mode)
				0: k = 1'b0;
				1: k = 1'b1;
				default: k = 1'($urandom_range(1));
			endcase
			offer_beat(pick_sample(), k, i == len - 1, 1'b0, 32'sd0, 1'b0);
		end
	endtask

	// receiver: random stalls, one long hold-off, quiet while steady
	initial begin
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			out_stall <= steady ? 1'b0 : ($urandom_range(99) < 35);
		end
	end

	always @(negedge clk) begin
		median_exp_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (median_q.size() == 0) begin
				$error("result with nothing expected: median_value %0d", median_value);
				mismatches++;
			end else begin
				e = median_q.pop_front();
				if (median_value !== e.med) begin
					$error("median_value: expected %0d, got %0d", e.med, median_value);
					mismatches++;
				end
				if (fallback_used !== e.fb) begin
					$error("fallback_used: expected %0b, got %0b", e.fb, fallback_used);
					mismatches++;
				end
				if (overflowed !== e.ov) begin
					$error("overflowed: expected %0b, got %0b", e.ov, overflowed);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int sent;
		int set_idx;
		int len;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		sample      = '0;
		keep        = 1'b0;
		last        = 1'b0;
		dropped     = 1'b0;
		mismatches  = 0;
		cycle_count = 0;
		steady      = 1'b0;
		hold_req    = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_beat(directed_rows[i].s, directed_rows[i].k, directed_rows[i].l,
				directed_rows[i].typed, directed_rows[i].med, directed_rows[i].fb);

		sent    = 0;
		set_idx = 0;
		while (sent < RAND_ITEMS) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
			steady = (sent >= 50 && sent < 100);
			if (set_idx == 3)
				hold_req = 1'b1;
			run_set(len);
			sent += len;
			set_idx++;
		end
		steady = 1'b0;

		// let the block drain completely once
		in_valid <= 1'b0;
		@(posedge clk);
		while (median_q.size() != 0)
			@(posedge clk);

		// fill to capacity, then drop the final beat
		run_set(CAPACITY + 1);
		run_set(3);

		in_valid <= 1'b0;
		@(posedge clk);
		while (median_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
